### rtl/blowfish_block_cipher_assert.svh
// Assertion macros for the block cipher core.
// The using scope provides clk_i and rst_ni.
`ifndef BLOWFISH_BLOCK_CIPHER_ASSERT_SVH
`define BLOWFISH_BLOCK_CIPHER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define BF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bf_pkg.sv
package bf_pkg;

  localparam int unsigned DefaultRounds = 16;
  localparam int unsigned SubkeyCount   = 18;
  localparam int unsigned SkIdxW        = 5;
  localparam int unsigned SboxCount     = 4;
  localparam int unsigned SboxEntries   = 256;
  localparam int unsigned SboxAddrW     = 8;
  localparam int unsigned WordW         = 32;
  localparam int unsigned IndexW        = 10;

  typedef enum logic [1:0] {
    ModeLoadSubkey = 2'd0,
    ModeLoadSbox   = 2'd1,
    ModeEncrypt    = 2'd2,
    ModeDecrypt    = 2'd3
  } bf_mode_e;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } bf_state_e;

  typedef struct packed {
    bf_mode_e          mode;
    logic [IndexW-1:0] table_index;
    logic [WordW-1:0]  left_half;
    logic [WordW-1:0]  right_half;
  } bf_in_t;

  typedef struct packed {
    logic [WordW-1:0] out_left;
    logic [WordW-1:0] out_right;
  } bf_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_sk;
    logic              load_sb;
    logic              start;
    logic              step;
    logic              finish;
    logic              decrypt;
    logic [SkIdxW-1:0] sk_next;
  } bf_cmd_t;

endpackage

### rtl/bf_ctrl.sv
module bf_ctrl #(
  parameter int unsigned ROUNDS = bf_pkg::DefaultRounds
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  bf_pkg::bf_in_t  in_item_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bf_pkg::bf_cmd_t cmd_o
);
  import bf_pkg::*;

  localparam int unsigned CntW = $clog2(ROUNDS);
  localparam logic [CntW-1:0] LastRound = CntW'(ROUNDS - 1);

  bf_state_e       state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            dec_q, dec_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic [SkIdxW-1:0] cnt_ext;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign cnt_ext     = {{(SkIdxW - CntW){1'b0}}, cnt_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dec_d   = dec_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (in_item_i.mode)
            ModeLoadSubkey: cmd_o.load_sk = (in_item_i.table_index < IndexW'(SubkeyCount));
            ModeLoadSbox:   cmd_o.load_sb = 1'b1;
            ModeEncrypt, ModeDecrypt: begin
              cmd_o.start = 1'b1;
              dec_d       = (in_item_i.mode == ModeDecrypt);
              cnt_d       = '0;
              state_d     = StRun;
            end
          endcase
        end
      end
      StRun: begin
        if (cnt_q == LastRound) begin
          // hold the last round until the output register is free
          if (!out_valid_q || out_ready_i) begin
            cmd_o.finish = 1'b1;
            state_d      = StIdle;
          end
        end else begin
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
    cmd_o.decrypt = cmd_o.start ? (in_item_i.mode == ModeDecrypt) : dec_q;
    // subkey of the following round: walk down for decryption
    cmd_o.sk_next = dec_q ? (SkIdxW'(ROUNDS) - cnt_ext) : (cnt_ext + 1'b1);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/bf_datapath.sv
module bf_datapath #(
  parameter int unsigned ROUNDS = bf_pkg::DefaultRounds
) (
  input  logic            clk_i,
  input  bf_pkg::bf_in_t  in_item_i,
  input  bf_pkg::bf_cmd_t cmd_i,
  output bf_pkg::bf_out_t out_item_o
);
  import bf_pkg::*;

  localparam logic [SkIdxW-1:0] IdxHi  = SkIdxW'(ROUNDS + 1);
  localparam logic [SkIdxW-1:0] IdxEnd = SkIdxW'(ROUNDS);

  logic [WordW-1:0]     sk_q [SubkeyCount];
  logic [WordW-1:0]     sb_rd_q [SboxCount];
  logic [SboxAddrW-1:0] sb_raddr [SboxCount];
  logic [WordW-1:0]     x_q, x_d;
  logic [WordW-1:0]     r_q, r_d;
  logic [WordW-1:0]     f_val, new_l;
  logic [WordW-1:0]     sk_first, sk_fin_l, sk_fin_r;
  bf_out_t              out_q;
  logic                 sb_re;

  assign sb_re = cmd_i.start || cmd_i.step;

  // F = ((S0 + S1) ^ S2) + S3, all additions mod 2^32
  assign f_val = ((sb_rd_q[0] + sb_rd_q[1]) ^ sb_rd_q[2]) + sb_rd_q[3];
  assign new_l = r_q ^ f_val;

  assign sk_first = cmd_i.decrypt ? sk_q[IdxHi] : sk_q[0];
  assign sk_fin_l = cmd_i.decrypt ? sk_q[0] : sk_q[IdxHi];
  assign sk_fin_r = cmd_i.decrypt ? sk_q[1] : sk_q[IdxEnd];

  always_comb begin
    x_d = x_q;
    r_d = r_q;
    if (cmd_i.start) begin
      x_d = in_item_i.left_half ^ sk_first;
      r_d = in_item_i.right_half;
    end else if (cmd_i.step) begin
      // swap halves and whiten the new left half for the next round
      x_d = new_l ^ sk_q[cmd_i.sk_next];
      r_d = x_q;
    end
  end

  for (genvar g = 0; g < SboxCount; g++) begin : g_sbox
    logic [WordW-1:0] mem_q [SboxEntries];

    assign sb_raddr[g] = x_d[(SboxCount - 1 - g) * SboxAddrW +: SboxAddrW];

    always_ff @(posedge clk_i) begin
      if (cmd_i.load_sb && (in_item_i.table_index[IndexW-1:SboxAddrW] == 2'(g))) begin
        mem_q[in_item_i.table_index[SboxAddrW-1:0]] <= in_item_i.left_half;
      end
      if (sb_re) begin
        sb_rd_q[g] <= mem_q[sb_raddr[g]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sk) begin
      sk_q[in_item_i.table_index[SkIdxW-1:0]] <= in_item_i.left_half;
    end
    x_q <= x_d;
    r_q <= r_d;
    if (cmd_i.finish) begin
      // undo the last swap and apply the output whitening
      out_q.out_left  <= x_q ^ sk_fin_l;
      out_q.out_right <= new_l ^ sk_fin_r;
    end
  end

  assign out_item_o = out_q;

endmodule

### rtl/blowfish_block_cipher.sv
// Blowfish 64-bit block cipher core. Load items (mode 0: subkey 0..17,
// higher indexes dropped; mode 1: S-box word at sbox*256+entry) are
// written on acceptance and give no result. An encrypt or decrypt item
// first whitens the left half and issues the first S-box lookups, then
// runs one Feistel round per cycle, paced by the registered read of the
// four 256-word S-box RAMs; the output whitening is folded into the last
// round. The result sits in an output register, so the next item is
// taken while it waits; a block whose result is due while the previous
// one is still untaken holds in its last round. Tables have no reset and
// must be written before use.
`include "blowfish_block_cipher_assert.svh"

module blowfish_block_cipher #(
  parameter int unsigned ROUNDS = bf_pkg::DefaultRounds
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bf_pkg::bf_in_t  in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bf_pkg::bf_out_t out_item_o
);
  import bf_pkg::*;

  bf_cmd_t cmd;

  bf_ctrl #(
    .ROUNDS(ROUNDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  bf_datapath #(
    .ROUNDS(ROUNDS)
  ) u_datapath (
    .clk_i     (clk_i),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .out_item_o(out_item_o)
  );

  `BF_ASSERT_NEXT(a_block_busy,
    in_valid_i && in_ready_o &&
    (in_item_i.mode == ModeEncrypt || in_item_i.mode == ModeDecrypt),
    !in_ready_o, "ready must drop while a block is in progress")
  `BF_ASSERT(a_no_overwrite, !cmd.finish || !out_valid_o || out_ready_i,
    "result written over an untaken item")
  `BF_ASSERT(a_valid_from_finish, !$rose(out_valid_o) || $past(cmd.finish),
    "output valid without a finished block")

endmodule
